>>> design/area_average_image_downscaler_macros.svh
// Assertion macros used by the checker of the downscaler.
`ifndef AREA_AVERAGE_IMAGE_DOWNSCALER_MACROS_SVH
`define AREA_AVERAGE_IMAGE_DOWNSCALER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("downscaler check failed");

// The consequent must hold in the cycle after the antecedent.
`define AAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("downscaler check failed");

`endif

>>> design/aad_pkg.sv
package aad_pkg;

	localparam int MAX_SOURCE_DIM_DEF = 1024;
	localparam int MAX_DEST_DIM_DEF = 64;
	localparam int SUM_W = 28;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST = 2'd2;

	localparam logic [10:0] SRC_W_RST = 11'd64;
	localparam logic [10:0] SRC_H_RST = 11'd64;
	localparam logic [6:0] DST_RST = 7'd64;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic image_done;
	} result_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] alpha;
	} sums_t;

	// A zero dimension counts as one; larger values saturate at hi.
	function automatic logic [31:0] clamp_dim(logic [31:0] v, logic [31:0] hi);
		logic [31:0] r;
		if (v == 32'd0) begin
			r = 32'd1;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> design/aad_front.sv
module aad_front #(
	parameter int MAX_SOURCE_DIM = aad_pkg::MAX_SOURCE_DIM_DEF,
	parameter int MAX_DEST_DIM = aad_pkg::MAX_DEST_DIM_DEF,
	localparam int NW = 2 * $clog2(MAX_SOURCE_DIM + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [aad_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [aad_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input aad_pkg::pixel_t in_data,
	output logic q_push,
	input logic q_full,
	output aad_pkg::sums_t q_sums,
	output logic [NW-1:0] q_count,
	output logic q_done
);
	import aad_pkg::*;

	localparam int SW = $clog2(MAX_SOURCE_DIM + 1);
	localparam int DDW = $clog2(MAX_DEST_DIM + 1);
	localparam int DCW = (MAX_DEST_DIM > 1) ? $clog2(MAX_DEST_DIM) : 1;
	localparam int ITW = $clog2(SW + 1);

	typedef enum logic [5:0] {
		ST_LOAD_W = 6'b000001,
		ST_DIV_W = 6'b000010,
		ST_LOAD_H = 6'b000100,
		ST_DIV_H = 6'b001000,
		ST_IDLE = 6'b010000,
		ST_ACC = 6'b100000
	} fstate_t;

	fstate_t state_q;

	logic [10:0] src_w_q, src_h_q;
	logic [6:0] dst_q;

	logic [31:0] w_full, h_full, d_full;
	logic [SW-1:0] w_eff, h_eff;
	logic [DDW-1:0] d_eff, nx, ny;

	assign w_full = clamp_dim(32'(src_w_q), 32'(MAX_SOURCE_DIM));
	assign h_full = clamp_dim(32'(src_h_q), 32'(MAX_SOURCE_DIM));
	assign d_full = clamp_dim(32'(dst_q), 32'(MAX_DEST_DIM));
	assign w_eff = w_full[SW-1:0];
	assign h_eff = h_full[SW-1:0];
	assign d_eff = d_full[DDW-1:0];
	// Fewer cells than dest_size when the source is narrower than the target.
	assign nx = (d_full < w_full) ? d_eff : w_full[DDW-1:0];
	assign ny = (d_full < h_full) ? d_eff : h_full[DDW-1:0];

	// Serial divider for the boundary steps src / cells.
	logic [SW-1:0] dv_num_q;
	logic [DDW-1:0] dv_rem_q;
	logic [ITW-1:0] dv_cnt_q;
	logic [DDW-1:0] dv_div;
	logic [DDW:0] dv_shift;
	logic dv_ge;
	logic [DDW-1:0] dv_rem_nx;
	logic [SW-1:0] dv_quo_nx;
	logic dv_last;

	assign dv_div = (state_q == ST_DIV_H) ? ny : nx;
	assign dv_shift = {dv_rem_q, dv_num_q[SW-1]};
	assign dv_ge = dv_shift >= {1'b0, dv_div};
	assign dv_rem_nx = dv_ge ? DDW'(dv_shift - {1'b0, dv_div}) : dv_shift[DDW-1:0];
	assign dv_quo_nx = {dv_num_q[SW-2:0], dv_ge};
	assign dv_last = dv_cnt_q == ITW'(SW - 1);

	logic [SW-1:0] cq_q, rq_q;
	logic [DDW-1:0] cr_q, rr_q;

	logic [SW-1:0] col_q, row_q, col_start_q, col_end_q, row_start_q, row_end_q;
	logic [DDW-1:0] col_rem_q, row_rem_q;
	logic [DCW-1:0] dcol_q, drow_q;

	pixel_t pix_q;
	sums_t rd_q, new_sums;
	sums_t sum_mem [MAX_DEST_DIM];

	logic first, col_last, row_last, col_wrap, row_wrap, emit, go;
	logic [SW-1:0] cw, ch;
	logic [DDW:0] c_sum, r_sum;
	logic c_carry, r_carry;
	logic [SW-1:0] col_end_nx, row_end_nx;
	logic [DDW-1:0] col_rem_nx, row_rem_nx;

	assign first = (row_q == row_start_q) && (col_q == col_start_q);
	assign col_last = ({1'b0, col_q} + 1'b1) >= {1'b0, col_end_q};
	assign row_last = ({1'b0, row_q} + 1'b1) >= {1'b0, row_end_q};
	assign col_wrap = col_end_q >= w_eff;
	assign row_wrap = row_end_q >= h_eff;
	assign emit = col_last && row_last;
	assign go = !emit || !q_full;

	assign c_sum = (DDW+1)'(col_rem_q) + (DDW+1)'(cr_q);
	assign c_carry = c_sum >= (DDW+1)'(nx);
	assign col_end_nx = col_end_q + cq_q + SW'(c_carry);
	assign col_rem_nx = c_carry ? DDW'(c_sum - (DDW+1)'(nx)) : c_sum[DDW-1:0];

	assign r_sum = (DDW+1)'(row_rem_q) + (DDW+1)'(rr_q);
	assign r_carry = r_sum >= (DDW+1)'(ny);
	assign row_end_nx = row_end_q + rq_q + SW'(r_carry);
	assign row_rem_nx = r_carry ? DDW'(r_sum - (DDW+1)'(ny)) : r_sum[DDW-1:0];

	assign cw = (col_end_q > col_start_q) ? col_end_q - col_start_q : SW'(1);
	assign ch = (row_end_q > row_start_q) ? row_end_q - row_start_q : SW'(1);

	always_comb begin
		if (first) begin
			new_sums.red = SUM_W'(pix_q.in_red);
			new_sums.green = SUM_W'(pix_q.in_green);
			new_sums.blue = SUM_W'(pix_q.in_blue);
			new_sums.alpha = SUM_W'(pix_q.in_alpha);
		end else begin
			new_sums.red = rd_q.red + SUM_W'(pix_q.in_red);
			new_sums.green = rd_q.green + SUM_W'(pix_q.in_green);
			new_sums.blue = rd_q.blue + SUM_W'(pix_q.in_blue);
			new_sums.alpha = rd_q.alpha + SUM_W'(pix_q.in_alpha);
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign q_push = (state_q == ST_ACC) && emit && !q_full;
	assign q_sums = new_sums;
	assign q_count = NW'(cw) * NW'(ch);
	assign q_done = ((DDW+1)'(drow_q) + 1'b1 >= (DDW+1)'(ny))
		&& ((DDW+1)'(dcol_q) + 1'b1 >= (DDW+1)'(nx));

	always_ff @(posedge clk) begin
		rd_q <= sum_mem[dcol_q];
		if ((state_q == ST_ACC) && go) begin
			sum_mem[dcol_q] <= new_sums;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			pix_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD_W;
			src_w_q <= SRC_W_RST;
			src_h_q <= SRC_H_RST;
			dst_q <= DST_RST;
			dv_num_q <= '0;
			dv_rem_q <= '0;
			dv_cnt_q <= '0;
			cq_q <= '0;
			cr_q <= '0;
			rq_q <= '0;
			rr_q <= '0;
			col_q <= '0;
			row_q <= '0;
			col_start_q <= '0;
			col_end_q <= '0;
			row_start_q <= '0;
			row_end_q <= '0;
			col_rem_q <= '0;
			row_rem_q <= '0;
			dcol_q <= '0;
			drow_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_W: src_w_q <= cfg_data[10:0];
				REG_SRC_H: src_h_q <= cfg_data[10:0];
				REG_DST: dst_q <= cfg_data[6:0];
				default: ;
			endcase
			// Any write restarts the frame; the steps are worked out again.
			state_q <= ST_LOAD_W;
		end else begin
			case (state_q)
				ST_LOAD_W, ST_LOAD_H: begin
					dv_num_q <= (state_q == ST_LOAD_W) ? w_eff : h_eff;
					dv_rem_q <= '0;
					dv_cnt_q <= '0;
					state_q <= (state_q == ST_LOAD_W) ? ST_DIV_W : ST_DIV_H;
				end
				ST_DIV_W, ST_DIV_H: begin
					dv_num_q <= dv_quo_nx;
					dv_rem_q <= dv_rem_nx;
					dv_cnt_q <= dv_cnt_q + 1'b1;
					if (dv_last) begin
						if (state_q == ST_DIV_W) begin
							cq_q <= dv_quo_nx;
							cr_q <= dv_rem_nx;
							state_q <= ST_LOAD_H;
						end else begin
							rq_q <= dv_quo_nx;
							rr_q <= dv_rem_nx;
							col_q <= '0;
							row_q <= '0;
							dcol_q <= '0;
							drow_q <= '0;
							col_start_q <= '0;
							row_start_q <= '0;
							col_end_q <= cq_q;
							col_rem_q <= cr_q;
							row_end_q <= dv_quo_nx;
							row_rem_q <= dv_rem_nx;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (go) begin
						state_q <= ST_IDLE;
						if (!col_last) begin
							col_q <= col_q + 1'b1;
						end else if (!col_wrap) begin
							col_q <= col_q + 1'b1;
							dcol_q <= dcol_q + 1'b1;
							col_start_q <= col_end_q;
							col_end_q <= col_end_nx;
							col_rem_q <= col_rem_nx;
						end else begin
							col_q <= '0;
							dcol_q <= '0;
							col_start_q <= '0;
							col_end_q <= cq_q;
							col_rem_q <= cr_q;
							if (!row_last) begin
								row_q <= row_q + 1'b1;
							end else if (!row_wrap) begin
								row_q <= row_q + 1'b1;
								drow_q <= drow_q + 1'b1;
								row_start_q <= row_end_q;
								row_end_q <= row_end_nx;
								row_rem_q <= row_rem_nx;
							end else begin
								// Last pixel of the image: back to the origin.
								row_q <= '0;
								drow_q <= '0;
								row_start_q <= '0;
								row_end_q <= rq_q;
								row_rem_q <= rr_q;
							end
						end
					end
				end
				default: state_q <= ST_LOAD_W;
			endcase
		end
	end

endmodule

>>> design/aad_queue.sv
module aad_queue #(
	parameter int WIDTH = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	output logic full,
	input logic pop,
	output logic nempty,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign nempty = cnt_q != 2'd0;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> design/aad_back.sv
module aad_back #(
	parameter int MAX_SOURCE_DIM = aad_pkg::MAX_SOURCE_DIM_DEF,
	localparam int NW = 2 * $clog2(MAX_SOURCE_DIM + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic q_nempty,
	output logic q_pop,
	input aad_pkg::sums_t q_sums,
	input logic [NW-1:0] q_count,
	input logic q_done,
	output logic out_valid,
	input logic out_stall,
	output aad_pkg::result_t out_data
);
	import aad_pkg::*;

	localparam int CNW = $clog2(SUM_W + 1);

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_DIV = 3'b010,
		BK_HOLD = 3'b100
	} bstate_t;

	bstate_t state_q;
	logic [SUM_W-1:0] num_q [4];
	logic [NW-1:0] rem_q [4];
	logic [NW-1:0] div_q;
	logic done_q;
	logic [CNW-1:0] cnt_q;
	logic out_valid_q;
	result_t out_q;

	logic [SUM_W-1:0] dvd [4];
	logic [SUM_W-1:0] num_nx [4];
	logic [NW-1:0] rem_nx [4];
	logic load_out;

	assign dvd[0] = q_sums.red;
	assign dvd[1] = q_sums.green;
	assign dvd[2] = q_sums.blue;
	assign dvd[3] = q_sums.alpha;

	// One quotient bit per cycle in each of the four channel lanes.
	always_comb begin
		logic [NW:0] sh;
		logic ge;
		for (int i = 0; i < 4; i++) begin
			sh = {rem_q[i], num_q[i][SUM_W-1]};
			ge = sh >= {1'b0, div_q};
			rem_nx[i] = ge ? NW'(sh - {1'b0, div_q}) : sh[NW-1:0];
			num_nx[i] = {num_q[i][SUM_W-2:0], ge};
		end
	end

	assign q_pop = (state_q == BK_IDLE) && q_nempty;
	assign load_out = (state_q == BK_HOLD) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 4; i++) begin
				num_q[i] <= dvd[i];
				rem_q[i] <= '0;
			end
			div_q <= q_count;
			done_q <= q_done;
		end else if (state_q == BK_DIV) begin
			for (int i = 0; i < 4; i++) begin
				num_q[i] <= num_nx[i];
				rem_q[i] <= rem_nx[i];
			end
		end
		if (load_out) begin
			out_q.out_red <= num_q[0][7:0];
			out_q.out_green <= num_q[1][7:0];
			out_q.out_blue <= num_q[2][7:0];
			out_q.out_alpha <= num_q[3][7:0];
			out_q.image_done <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (q_nempty) begin
						cnt_q <= '0;
						state_q <= BK_DIV;
					end
				end
				BK_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNW'(SUM_W - 1)) begin
						state_q <= BK_HOLD;
					end
				end
				BK_HOLD: begin
					if (load_out) begin
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

>>> design/area_average_image_downscaler.sv
// Channel  | Direction | Handshake           | Payload
// in       | input     | in_valid/in_stall   | in_data (pixel_t): one source pixel
// out      | output    | out_valid/out_stall | out_data (result_t): one averaged cell
// cfg      | input     | cfg_we              | cfg_index, cfg_data: register write
//
// The front end reads the column sums as it takes a pixel, then adds and writes them
// back; it takes no new pixel until the write-back is done. Each finished cell is
// divided in the back end, one quotient bit per cycle, and the back end pops no new
// cell until the last result is loaded into its output register. After reset and
// after every register write the front end works out the boundary steps, with
// in_stall high. A two-entry queue separates the halves; a full queue stalls only
// the pixel that closes a cell.
module area_average_image_downscaler #(
	parameter int MAX_SOURCE_DIM = aad_pkg::MAX_SOURCE_DIM_DEF,
	parameter int MAX_DEST_DIM = aad_pkg::MAX_DEST_DIM_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [aad_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [aad_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input aad_pkg::pixel_t in_data,
	output logic out_valid,
	input logic out_stall,
	output aad_pkg::result_t out_data
);
	import aad_pkg::*;

	localparam int NW = 2 * $clog2(MAX_SOURCE_DIM + 1);
	localparam int QW = 4 * SUM_W + NW + 1;

	logic q_push, q_full, q_pop, q_nempty, f_done, b_done;
	sums_t f_sums, b_sums;
	logic [NW-1:0] f_count, b_count;
	logic [QW-1:0] q_rdata;

	aad_front #(
		.MAX_SOURCE_DIM(MAX_SOURCE_DIM),
		.MAX_DEST_DIM(MAX_DEST_DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.q_push(q_push),
		.q_full(q_full),
		.q_sums(f_sums),
		.q_count(f_count),
		.q_done(f_done)
	);

	aad_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata({f_sums, f_count, f_done}),
		.full(q_full),
		.pop(q_pop),
		.nempty(q_nempty),
		.rdata(q_rdata)
	);

	assign {b_sums, b_count, b_done} = q_rdata;

	aad_back #(
		.MAX_SOURCE_DIM(MAX_SOURCE_DIM)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_nempty(q_nempty),
		.q_pop(q_pop),
		.q_sums(b_sums),
		.q_count(b_count),
		.q_done(b_done),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

>>> design/aad_checker.sv
`include "area_average_image_downscaler_macros.svh"

module aad_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic in_valid,
	input logic in_stall,
	input aad_pkg::pixel_t in_data,
	input logic out_valid,
	input logic out_stall,
	input aad_pkg::result_t out_data
);

	// A stalled result keeps its valid and its value.
	`AAD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	// A result only goes away through a transfer.
	`AAD_ASSERT_NOW(a_out_drop, clk, arst_n, $fell(out_valid), $past(!out_stall))
	// A register write makes the block recompute its steps before taking pixels.
	`AAD_ASSERT_NEXT(a_cfg_recalc, clk, arst_n, cfg_we, in_stall)
	// Each pixel transfer is followed by the write-back cycle of its sums.
	`AAD_ASSERT_NEXT(a_pix_gap, clk, arst_n, in_valid && !in_stall, in_stall)
	// A stalled pixel keeps its valid and its value.
	`AAD_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(in_data))

endmodule

bind area_average_image_downscaler aad_checker u_aad_checker (.*);
